// ===== rtl/pidmix_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmix_pkg
// Shared widths, register codes, reset values and control types of the
// six-channel pid obstacle-avoidance wheel mixer.
// ----------------------------------------------------------------------------
package pidmix_pkg;

    localparam int CHANNELS           = 6;
    localparam int READING_BITS_DEF   = 12;
    localparam int GAIN_FRAC_BITS_DEF = 24;

    localparam int GAIN_W          = 28;
    localparam int SAFE_W          = 12;
    localparam int SPEED_W         = 13;
    localparam int SUM_W           = 32;
    localparam int SPEED_FRAC_BITS = 10;
    localparam int CORR_W          = 14;
    localparam int SPD_OUT_W       = 14;
    localparam int MIX_W           = 17;
    localparam int OUT_TDATA_W     = ((2 * SPD_OUT_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_DISTANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORRECTION = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN      = 28'd2516582;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN     = 28'd537;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN     = 28'd26214400;
    localparam logic [SAFE_W-1:0]  RST_SAFE_DISTANCE  = 12'd80;
    localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED   = 13'd4096;
    localparam logic [SPEED_W-1:0] RST_MAX_CORRECTION = 13'd1608;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain_times_step;
        logic [GAIN_W-1:0]  deriv_gain_over_step;
        logic [SAFE_W-1:0]  safe_distance;
        logic [SPEED_W-1:0] cruise_speed;
        logic [SPEED_W-1:0] max_correction;
    } t_cfg;

    // stage advance strobes, one per register boundary
    typedef struct packed {
        logic to_s1;
        logic to_s2;
        logic to_s3;
        logic to_out;
    } t_adv;

endpackage

// ===== rtl/pidmix_err_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmix_err_stage
// Per-channel error, saturating error sum and error difference; holds the
// running sums and previous errors of all six channels.
// ----------------------------------------------------------------------------
module pidmix_err_stage #(
    parameter int READING_BITS = pidmix_pkg::READING_BITS_DEF,
    localparam int ERR_W = ((READING_BITS > pidmix_pkg::SAFE_W) ?
                            READING_BITS : pidmix_pkg::SAFE_W) + 1,
    localparam int DIFF_W = ERR_W + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pidmix_pkg::t_adv                  i_adv,
    input  logic [pidmix_pkg::SAFE_W-1:0]     i_safe_distance,
    input  logic [READING_BITS-1:0]           i_reading [pidmix_pkg::CHANNELS],
    output logic signed [ERR_W-1:0]           o_err     [pidmix_pkg::CHANNELS],
    output logic signed [pidmix_pkg::SUM_W-1:0] o_sum   [pidmix_pkg::CHANNELS],
    output logic signed [DIFF_W-1:0]          o_diff    [pidmix_pkg::CHANNELS],
    output logic                              o_near    [pidmix_pkg::CHANNELS]
);
    import pidmix_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic signed [SUM_W-1:0]  r_sum  [CHANNELS];
    logic signed [ERR_W-1:0]  r_prev [CHANNELS];
    logic signed [ERR_W-1:0]  r_err  [CHANNELS];
    logic signed [SUM_W-1:0]  r_sat  [CHANNELS];
    logic signed [DIFF_W-1:0] r_diff [CHANNELS];
    logic                     r_near [CHANNELS];

    logic signed [ERR_W-1:0]  n_err  [CHANNELS];
    logic signed [SUM_W:0]    w_wide [CHANNELS];
    logic signed [SUM_W-1:0]  n_sum  [CHANNELS];
    logic signed [DIFF_W-1:0] n_diff [CHANNELS];
    logic                     n_near [CHANNELS];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_err[c]  = $signed(ERR_W'(i_safe_distance)) - $signed(ERR_W'(i_reading[c]));
            w_wide[c] = (SUM_W+1)'(r_sum[c]) + (SUM_W+1)'(n_err[c]);
            // overflow when the two top bits disagree
            if (w_wide[c][SUM_W] != w_wide[c][SUM_W-1]) begin
                n_sum[c] = w_wide[c][SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                n_sum[c] = w_wide[c][SUM_W-1:0];
            end
            n_diff[c] = DIFF_W'(n_err[c]) - DIFF_W'(r_prev[c]);
            n_near[c] = ERR_W'(i_reading[c]) > ERR_W'(i_safe_distance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]  <= '0;
                r_prev[c] <= '0;
            end
        end else if (i_adv.to_s1) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]  <= n_sum[c];
                r_prev[c] <= n_err[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.to_s1) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_err[c]  <= n_err[c];
                r_sat[c]  <= n_sum[c];
                r_diff[c] <= n_diff[c];
                r_near[c] <= n_near[c];
            end
        end
    end

    assign o_err  = r_err;
    assign o_sum  = r_sat;
    assign o_diff = r_diff;
    assign o_near = r_near;

endmodule

// ===== rtl/pidmix_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmix_lane
// One pid lane: three gain products, then sum, floor shift to Q10 and
// symmetric clamp to the correction limit.
// ----------------------------------------------------------------------------
module pidmix_lane #(
    parameter int READING_BITS   = pidmix_pkg::READING_BITS_DEF,
    parameter int GAIN_FRAC_BITS = pidmix_pkg::GAIN_FRAC_BITS_DEF,
    localparam int ERR_W = ((READING_BITS > pidmix_pkg::SAFE_W) ?
                            READING_BITS : pidmix_pkg::SAFE_W) + 1,
    localparam int DIFF_W = ERR_W + 1
) (
    input  logic                                i_clk,
    input  pidmix_pkg::t_adv                    i_adv,
    input  pidmix_pkg::t_cfg                    i_cfg,
    input  logic signed [ERR_W-1:0]             i_err,
    input  logic signed [pidmix_pkg::SUM_W-1:0] i_sum,
    input  logic signed [DIFF_W-1:0]            i_diff,
    input  logic                                i_near,
    output logic signed [pidmix_pkg::CORR_W-1:0] o_corr,
    output logic                                o_near
);
    import pidmix_pkg::*;

    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int I_W   = GAIN_W + 1 + SUM_W;
    localparam int D_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W = I_W + 2;
    localparam int SHIFT = GAIN_FRAC_BITS - SPEED_FRAC_BITS;

    logic signed [P_W-1:0]    r_prod_p;
    logic signed [I_W-1:0]    r_prod_i;
    logic signed [D_W-1:0]    r_prod_d;
    logic                     r_near2;
    logic signed [CORR_W-1:0] r_corr;
    logic                     r_near3;

    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_shifted;
    logic signed [ACC_W-1:0]  w_lim;
    logic signed [CORR_W-1:0] n_corr;

    always_ff @(posedge i_clk) begin
        if (i_adv.to_s2) begin
            r_prod_p <= P_W'($signed({1'b0, i_cfg.prop_gain})) * P_W'(i_err);
            r_prod_i <= I_W'($signed({1'b0, i_cfg.integ_gain_times_step})) * I_W'(i_sum);
            r_prod_d <= D_W'($signed({1'b0, i_cfg.deriv_gain_over_step})) * D_W'(i_diff);
            r_near2  <= i_near;
        end
    end

    always_comb begin
        w_acc     = ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
        // arithmetic shift rounds toward minus infinity
        w_shifted = w_acc >>> SHIFT;
        w_lim     = ACC_W'($signed({1'b0, i_cfg.max_correction}));
        if (w_shifted > w_lim) begin
            n_corr = CORR_W'(w_lim);
        end else if (w_shifted < -w_lim) begin
            n_corr = CORR_W'(-w_lim);
        end else begin
            n_corr = CORR_W'(w_shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.to_s3) begin
            r_corr  <= n_corr;
            r_near3 <= r_near2;
        end
    end

    assign o_corr = r_corr;
    assign o_near = r_near3;

endmodule

// ===== rtl/pidmix_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmix_mixer
// Mixes the lane corrections into two wheel speeds by obstacle group and
// holds the result register.
// ----------------------------------------------------------------------------
module pidmix_mixer (
    input  logic                                  i_clk,
    input  pidmix_pkg::t_adv                      i_adv,
    input  logic [pidmix_pkg::SPEED_W-1:0]        i_cruise_speed,
    input  logic signed [pidmix_pkg::CORR_W-1:0]  i_corr [pidmix_pkg::CHANNELS],
    input  logic                                  i_near [pidmix_pkg::CHANNELS],
    output logic signed [pidmix_pkg::SPD_OUT_W-1:0] o_left_wheel_speed,
    output logic signed [pidmix_pkg::SPD_OUT_W-1:0] o_right_wheel_speed
);
    import pidmix_pkg::*;

    logic signed [SPD_OUT_W-1:0] r_left;
    logic signed [SPD_OUT_W-1:0] r_right;

    logic signed [MIX_W-1:0] w_base;
    logic signed [MIX_W-1:0] w_c [CHANNELS];
    logic signed [MIX_W-1:0] w_left;
    logic signed [MIX_W-1:0] w_right;
    logic signed [SPD_OUT_W-1:0] n_left;
    logic signed [SPD_OUT_W-1:0] n_right;

    always_comb begin
        w_base = MIX_W'($signed({1'b0, i_cruise_speed}));
        for (int c = 0; c < CHANNELS; c++) begin
            w_c[c] = MIX_W'(i_corr[c]);
        end
        w_left  = w_base;
        w_right = w_base;
        // front group
        if (i_near[0] || i_near[5]) begin
            w_left  = w_left - w_base - w_c[0];
            w_right = w_right + w_base + w_c[5];
        end
        // left group
        if (i_near[3] || i_near[4]) begin
            w_left  = w_left + w_c[3];
            w_right = w_right - w_c[4];
        end
        // right group
        if (i_near[2] || i_near[1]) begin
            w_left  = w_left - w_c[2];
            w_right = w_right + w_c[1];
        end
        if (w_left > w_base) begin
            n_left = SPD_OUT_W'(w_base);
        end else if (w_left < -w_base) begin
            n_left = SPD_OUT_W'(-w_base);
        end else begin
            n_left = SPD_OUT_W'(w_left);
        end
        if (w_right > w_base) begin
            n_right = SPD_OUT_W'(w_base);
        end else if (w_right < -w_base) begin
            n_right = SPD_OUT_W'(-w_base);
        end else begin
            n_right = SPD_OUT_W'(w_right);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.to_out) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_left_wheel_speed  = r_left;
    assign o_right_wheel_speed = r_right;

endmodule

// ===== rtl/multi_sensor_pid_avoidance_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_sensor_pid_avoidance_mixer
// Six-channel pid obstacle avoidance: proximity frame in, wheel speeds out.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one transfer per control tick, six readings packed in tdata.
//   m_axis: one transfer per tick, left and right wheel speeds (signed Q10).
//   cfg: write enable, register index and data; write only while no tick is
//   in flight. Indexes above the last register are ignored.
// Path: a result passes the input register, error/sum stage, gain
//   products, clamp and mix/output register before it is offered.
// Throughput: one tick per cycle; every stage hands on independently, so a
//   stalled output register only stops input once all stages are full.
// Reset (synchronous, active low): pipeline emptied, error sums and
//   previous errors cleared, registers back to their defaults; s_axis
//   tready is high in the first cycle after reset.
// Stall: while m_axis tready is low the output result holds and the stages
//   behind it keep filling; s_axis tready drops when the last one is full.
// ----------------------------------------------------------------------------
module multi_sensor_pid_avoidance_mixer #(
    parameter int READING_BITS   = pidmix_pkg::READING_BITS_DEF,
    parameter int GAIN_FRAC_BITS = pidmix_pkg::GAIN_FRAC_BITS_DEF,
    localparam int IN_TDATA_W = ((pidmix_pkg::CHANNELS * READING_BITS + 7) / 8) * 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // front_right, right_diag, right_side, left_side, left_diag, front_left
    input  logic [IN_TDATA_W-1:0]                i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // left_wheel_speed, right_wheel_speed, zero fill
    output logic [pidmix_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [pidmix_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pidmix_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pidmix_pkg::*;

    localparam int ERR_W  = ((READING_BITS > SAFE_W) ? READING_BITS : SAFE_W) + 1;
    localparam int DIFF_W = ERR_W + 1;

    t_cfg r_cfg;
    logic r_v0, r_v1, r_v2, r_v3, r_vo;
    logic [READING_BITS-1:0] r_reading [CHANNELS];

    logic w_rdy_o, w_rdy3, w_rdy2, w_rdy1, w_in_xfer;
    t_adv w_adv;

    logic signed [ERR_W-1:0]     w_err   [CHANNELS];
    logic signed [SUM_W-1:0]     w_sum   [CHANNELS];
    logic signed [DIFF_W-1:0]    w_diff  [CHANNELS];
    logic                        w_near1 [CHANNELS];
    logic signed [CORR_W-1:0]    w_corr  [CHANNELS];
    logic                        w_near3 [CHANNELS];
    logic signed [SPD_OUT_W-1:0] w_left;
    logic signed [SPD_OUT_W-1:0] w_right;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain             <= RST_PROP_GAIN;
            r_cfg.integ_gain_times_step <= RST_INTEG_GAIN;
            r_cfg.deriv_gain_over_step  <= RST_DERIV_GAIN;
            r_cfg.safe_distance         <= RST_SAFE_DISTANCE;
            r_cfg.cruise_speed          <= RST_CRUISE_SPEED;
            r_cfg.max_correction        <= RST_MAX_CORRECTION;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:      r_cfg.prop_gain <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:     r_cfg.integ_gain_times_step <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:     r_cfg.deriv_gain_over_step <= i_cfg_data[GAIN_W-1:0];
                REG_SAFE_DISTANCE:  r_cfg.safe_distance <= i_cfg_data[SAFE_W-1:0];
                REG_CRUISE_SPEED:   r_cfg.cruise_speed <= i_cfg_data[SPEED_W-1:0];
                REG_MAX_CORRECTION: r_cfg.max_correction <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its content moves on
    assign w_rdy_o = !r_vo || i_m_axis_tready;
    assign w_rdy3  = !r_v3 || w_rdy_o;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_s_axis_tready = !r_v0 || w_rdy1;
    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;

    assign w_adv.to_s1  = r_v0 && w_rdy1;
    assign w_adv.to_s2  = r_v1 && w_rdy2;
    assign w_adv.to_s3  = r_v2 && w_rdy3;
    assign w_adv.to_out = r_v3 && w_rdy_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_in_xfer)        r_v0 <= 1'b1;
            else if (w_adv.to_s1) r_v0 <= 1'b0;
            if (w_adv.to_s1)      r_v1 <= 1'b1;
            else if (w_adv.to_s2) r_v1 <= 1'b0;
            if (w_adv.to_s2)      r_v2 <= 1'b1;
            else if (w_adv.to_s3) r_v2 <= 1'b0;
            if (w_adv.to_s3)      r_v3 <= 1'b1;
            else if (w_adv.to_out) r_v3 <= 1'b0;
            if (w_adv.to_out)     r_vo <= 1'b1;
            else if (i_m_axis_tready) r_vo <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_reading[c] <= i_s_axis_tdata[c*READING_BITS +: READING_BITS];
            end
        end
    end

    pidmix_err_stage #(
        .READING_BITS (READING_BITS)
    ) u_err_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_safe_distance (r_cfg.safe_distance),
        .i_reading       (r_reading),
        .o_err           (w_err),
        .o_sum           (w_sum),
        .o_diff          (w_diff),
        .o_near          (w_near1)
    );

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        pidmix_lane #(
            .READING_BITS   (READING_BITS),
            .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_adv  (w_adv),
            .i_cfg  (r_cfg),
            .i_err  (w_err[g]),
            .i_sum  (w_sum[g]),
            .i_diff (w_diff[g]),
            .i_near (w_near1[g]),
            .o_corr (w_corr[g]),
            .o_near (w_near3[g])
        );
    end

    pidmix_mixer u_mixer (
        .i_clk               (i_clk),
        .i_adv               (w_adv),
        .i_cruise_speed      (r_cfg.cruise_speed),
        .i_corr              (w_corr),
        .i_near              (w_near3),
        .o_left_wheel_speed  (w_left),
        .o_right_wheel_speed (w_right)
    );

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - 2*SPD_OUT_W)'(0), w_right, w_left};

endmodule

// ===== rtl/pidmix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidmix_checker
// Port-level checks of the wheel mixer, bound to the top level.
// ----------------------------------------------------------------------------
module pidmix_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [pidmix_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import pidmix_pkg::*;

    localparam logic [SPD_OUT_W-1:0] SPD_MIN_CODE = {1'b1, {(SPD_OUT_W-1){1'b0}}};

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // speeds are clamped to plus or minus cruise speed, never the most negative code
    a_spd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[SPD_OUT_W-1:0] != SPD_MIN_CODE &&
                            o_m_axis_tdata[2*SPD_OUT_W-1:SPD_OUT_W] != SPD_MIN_CODE)
        else $error("wheel speed outside clamp");

    // pipeline empty after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("not empty after reset");

    // input back-pressure only once a result is waiting on a stalled receiver
    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output stall");

endmodule

bind multi_sensor_pid_avoidance_mixer pidmix_checker u_pidmix_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the six-channel pid obstacle-avoidance wheel mixer.
// A directed table covers reading extremes, every obstacle group, the zero
// clamps, spare register indexes and over-wide register values. Random
// sensor frames then run under several register settings, and a short
// back-to-back soak pushes full-scale errors of both signs through the sums.
// Every result transfer is checked against a cycle-free model of the six
// pid lanes, or against the speeds that a directed row gives.
// ----------------------------------------------------------------------------
module tb_top;
    import pidmix_pkg::*;

    localparam int RD_W        = READING_BITS_DEF;
    localparam int SHIFT       = GAIN_FRAC_BITS_DEF - SPEED_FRAC_BITS;
    localparam int WATCHDOG    = 4000;
    localparam int TAIL        = 12;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_TICKS = 200;
    localparam int LAST_TICKS  = 150;
    localparam int SOAK_TICKS  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [RD_W-1:0]    RD_MAX    = '1;
    localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -64'sd2147483648;

    // channel 0 (front right) in the lowest bits
    typedef logic [CHANNELS-1:0][RD_W-1:0] t_frame;

    typedef struct packed {
        logic signed [SPD_OUT_W-1:0] left;
        logic signed [SPD_OUT_W-1:0] right;
    } t_speeds;

    typedef enum logic {
        ROW_CFG,
        ROW_TICK
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_frame                frame;
        logic                  has_want;
        t_speeds               want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   s_valid  = 1'b0;
    logic                   s_ready;
    t_frame                 s_data   = '0;
    logic                   m_valid;
    logic                   m_ready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    int rx_hold      = 0;
    int quiet_cycles = 0;
    int n_mismatch   = 0;

    t_speeds expected_speeds[$];
    t_row    dir_rows[$];

    // model copy of the registers and of the per-lane state
    logic [GAIN_W-1:0]  kp       = RST_PROP_GAIN;
    logic [GAIN_W-1:0]  ki_dt    = RST_INTEG_GAIN;
    logic [GAIN_W-1:0]  kd_dt    = RST_DERIV_GAIN;
    logic [SAFE_W-1:0]  setpoint = RST_SAFE_DISTANCE;
    logic [SPEED_W-1:0] cruise   = RST_CRUISE_SPEED;
    logic [SPEED_W-1:0] corr_lim = RST_MAX_CORRECTION;
    int                 err_sum  [CHANNELS];
    logic signed [RD_W:0] last_err [CHANNELS];

    multi_sensor_pid_avoidance_mixer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint clamp_mag(input longint x, input longint lim);
        if (x > lim) return lim;
        if (x < -lim) return -lim;
        return x;
    endfunction

    task automatic predict_speeds(input t_frame f, output t_speeds o);
        longint e, s, acc, base, left, right;
        longint corr [CHANNELS];
        logic   near_ch [CHANNELS];
        base = longint'(cruise);
        for (int k = 0; k < CHANNELS; k++) begin
            e = longint'(setpoint) - longint'(f[k]);
            s = longint'(err_sum[k]) + e;
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            err_sum[k] = int'(s);
            acc = longint'(kp) * e + longint'(ki_dt) * s
                + longint'(kd_dt) * (e - longint'(last_err[k]));
            corr[k] = clamp_mag(acc >>> SHIFT, longint'(corr_lim));
            last_err[k] = e[RD_W:0];
            near_ch[k] = f[k] > setpoint;
        end
        left  = base;
        right = base;
        if (near_ch[0] || near_ch[5]) begin
            left  -= base + corr[0];
            right += base + corr[5];
        end
        if (near_ch[3] || near_ch[4]) begin
            left  += corr[3];
            right -= corr[4];
        end
        if (near_ch[2] || near_ch[1]) begin
            left  -= corr[2];
            right += corr[1];
        end
        left    = clamp_mag(left, base);
        right   = clamp_mag(right, base);
        o.left  = left[SPD_OUT_W-1:0];
        o.right = right[SPD_OUT_W-1:0];
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 4))
            0: return '0;
            1: return GAIN_MAX;
            2: return r[GAIN_W-1:0];
            default: begin
                r = $urandom_range(0, 1 << 18);
                return r[GAIN_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [RD_W-1:0] pick_reading(input logic [SAFE_W-1:0] sd);
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = int'(RD_MAX);
            // hug the near threshold
            2, 3: v = int'(sd) - 3 + int'($urandom_range(0, 6));
            default: v = $urandom_range(0, int'(RD_MAX));
        endcase
        if (v < 0) v = 0;
        if (v > int'(RD_MAX)) v = int'(RD_MAX);
        return v[RD_W-1:0];
    endfunction

    function automatic t_frame lone(input int k);
        t_frame f;
        f = '0;
        f[k] = RD_MAX;
        return f;
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_tick(input t_frame f);
        t_row r;
        r = '0;
        r.kind = ROW_TICK;
        r.frame = f;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_want(input t_frame f, input logic signed [SPD_OUT_W-1:0] l,
                                     input logic signed [SPD_OUT_W-1:0] rt);
        t_row r;
        r = '0;
        r.kind = ROW_TICK;
        r.frame = f;
        r.has_want = 1'b1;
        r.want.left = l;
        r.want.right = rt;
        dir_rows.push_back(r);
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PROP_GAIN:      kp       = data[GAIN_W-1:0];
            REG_INTEG_GAIN:     ki_dt    = data[GAIN_W-1:0];
            REG_DERIV_GAIN:     kd_dt    = data[GAIN_W-1:0];
            REG_SAFE_DISTANCE:  setpoint = data[SAFE_W-1:0];
            REG_CRUISE_SPEED:   cruise   = data[SPEED_W-1:0];
            REG_MAX_CORRECTION: corr_lim = data[SPEED_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // stop offering frames and let every outstanding result transfer complete
    task automatic wait_settled();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (expected_speeds.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send_frame(input t_frame f, input logic has_want, input t_speeds want);
        t_speeds calc;
        int      gap;
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= f;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_speeds(f, calc);
        expected_speeds.push_back(has_want ? want : calc);
        gap = 0;
        if (!tx_steady && $urandom_range(0, 9) < 4) gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic set_phase(input int p);
        logic [GAIN_W-1:0]  gp, gi, gd;
        logic [SAFE_W-1:0]  sd;
        logic [SPEED_W-1:0] cs, mc;
        logic [31:0]        r, junk;
        r = $urandom;
        case (p)
            0: begin
                gp = RST_PROP_GAIN;
                gi = RST_INTEG_GAIN;
                gd = RST_DERIV_GAIN;
                sd = RST_SAFE_DISTANCE;
                cs = RST_CRUISE_SPEED;
                mc = RST_MAX_CORRECTION;
            end
            1: begin
                gp = GAIN_MAX;
                gi = GAIN_MAX;
                gd = GAIN_MAX;
                sd = r[SAFE_W-1:0];
                cs = SPEED_MAX;
                mc = SPEED_MAX;
            end
            2: begin
                gp = '0;
                gi = '0;
                gd = '0;
                sd = '0;
                cs = r[SPEED_W-1:0];
                mc = '0;
            end
            default: begin
                gp = pick_gain();
                gi = pick_gain();
                gd = pick_gain();
                sd = r[SAFE_W-1:0];
                cs = r[SAFE_W+SPEED_W-1:SAFE_W];
                r  = $urandom;
                mc = r[31] ? r[SPEED_W-1:0] : {5'd0, r[7:0]};
            end
        endcase
        // junk above each narrow register must be dropped by the block
        junk = $urandom;
        cfg_write(REG_PROP_GAIN, gp);
        cfg_write(REG_INTEG_GAIN, gi);
        cfg_write(REG_DERIV_GAIN, gd);
        cfg_write(REG_SAFE_DISTANCE, {junk[15:0], sd});
        cfg_write(REG_CRUISE_SPEED, {junk[30:16], cs});
        cfg_write(REG_MAX_CORRECTION, {junk[14:0], mc});
    endtask

    task automatic run_random(input int count);
        t_frame f;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 149) == 0) wait_settled();
            for (int k = 0; k < CHANNELS; k++) f[k] = pick_reading(setpoint);
            send_frame(f, 1'b0, '0);
        end
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        if (rx_hold == 0 && !rx_steady && $urandom_range(0, 3) == 0) rx_hold = pick_gap();
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : speed_check
        t_speeds                     want;
        logic signed [SPD_OUT_W-1:0] got_l, got_r;
        if (i_rst_n && m_valid && m_ready) begin
            got_l = m_data[SPD_OUT_W-1:0];
            got_r = m_data[2*SPD_OUT_W-1:SPD_OUT_W];
            if (expected_speeds.size() == 0) begin
                $error("wheel speed transfer with nothing outstanding: left %0d right %0d",
                       got_l, got_r);
                n_mismatch++;
            end else begin
                want = expected_speeds.pop_front();
                if (got_l !== want.left) begin
                    $error("left_wheel_speed: expected %0d, got %0d", want.left, got_l);
                    n_mismatch++;
                end
                if (got_r !== want.right) begin
                    $error("right_wheel_speed: expected %0d, got %0d", want.right, got_r);
                    n_mismatch++;
                end
                if (m_data[OUT_TDATA_W-1:2*SPD_OUT_W] !== '0) begin
                    $error("tdata fill: expected 0, got %h",
                           m_data[OUT_TDATA_W-1:2*SPD_OUT_W]);
                    n_mismatch++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_frame f;
        for (int k = 0; k < CHANNELS; k++) begin
            err_sum[k]  = 0;
            last_err[k] = '0;
        end

        // nothing near, both wheels at cruise
        row_want({CHANNELS{12'd0}}, 14'sd4096, 14'sd4096);
        row_tick({CHANNELS{RD_MAX}});
        // a reading equal to the threshold is not near
        row_want({CHANNELS{12'd80}}, 14'sd4096, 14'sd4096);
        row_tick({CHANNELS{12'd81}});
        for (int k = 0; k < CHANNELS; k++) row_tick(lone(k));
        row_tick({CHANNELS{12'hAAA}});
        row_tick({CHANNELS{12'h555}});
        // zero correction clamp leaves only the front swerve
        row_cfg(REG_MAX_CORRECTION, '0);
        row_want({CHANNELS{RD_MAX}}, 14'sd0, 14'sd4096);
        row_cfg(REG_CRUISE_SPEED, '0);
        row_want({CHANNELS{12'h5A5}}, 14'sd0, 14'sd0);
        // spare indexes must not land anywhere
        row_cfg(REG_SPARE_LO, GAIN_MAX);
        row_cfg(REG_SPARE_HI, 28'h1234567);
        row_want({CHANNELS{RD_MAX}}, 14'sd0, 14'sd0);
        row_cfg(REG_SAFE_DISTANCE, 28'hFFFF050);
        row_cfg(REG_CRUISE_SPEED, 28'hFFFF000);
        row_want({CHANNELS{12'd80}}, 14'sd4096, 14'sd4096);
        row_cfg(REG_MAX_CORRECTION, SPEED_MAX);
        row_cfg(REG_PROP_GAIN, GAIN_MAX);
        row_cfg(REG_INTEG_GAIN, GAIN_MAX);
        row_cfg(REG_DERIV_GAIN, GAIN_MAX);
        row_cfg(REG_CRUISE_SPEED, SPEED_MAX);
        row_tick({CHANNELS{RD_MAX}});
        row_tick({CHANNELS{12'd0}});
        row_tick(lone(0));
        row_cfg(REG_PROP_GAIN, '0);
        row_cfg(REG_INTEG_GAIN, '0);
        row_cfg(REG_DERIV_GAIN, '0);
        row_want(lone(0), 14'sd0, 14'sd8191);
        row_cfg(REG_SAFE_DISTANCE, '0);
        row_want({CHANNELS{12'd0}}, 14'sd8191, 14'sd8191);
        row_cfg(REG_SAFE_DISTANCE, RD_MAX);
        row_want({CHANNELS{RD_MAX}}, 14'sd8191, 14'sd8191);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_settled();
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                send_frame(dir_rows[r].frame, dir_rows[r].has_want, dir_rows[r].want);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_settled();
            set_phase(p);
            run_random(PHASE_TICKS);
        end

        // soak: right-hand lanes see full positive error while the left-hand
        // lanes see zero, then the left-hand lanes see full negative error
        wait_settled();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        cfg_write(REG_PROP_GAIN, GAIN_MAX);
        cfg_write(REG_INTEG_GAIN, GAIN_MAX);
        cfg_write(REG_DERIV_GAIN, GAIN_MAX);
        cfg_write(REG_CRUISE_SPEED, RST_CRUISE_SPEED);
        cfg_write(REG_MAX_CORRECTION, SPEED_MAX);
        cfg_write(REG_SAFE_DISTANCE, RD_MAX);
        f = {RD_MAX, RD_MAX, RD_MAX, 12'd0, 12'd0, 12'd0};
        repeat (SOAK_TICKS) send_frame(f, 1'b0, '0);
        wait_settled();
        cfg_write(REG_SAFE_DISTANCE, '0);
        repeat (SOAK_TICKS) send_frame(f, 1'b0, '0);

        wait_settled();
        set_phase(RAND_PHASES);
        run_random(LAST_TICKS);

        wait_settled();
        repeat (TAIL) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
